// ===== rtl/ljpef_pkg.sv =====
package ljpef_pkg;

	localparam logic [2:0] REG_EPS_00 = 3'd0;
	localparam logic [2:0] REG_EPS_01 = 3'd1;
	localparam logic [2:0] REG_EPS_11 = 3'd2;
	localparam logic [2:0] REG_RM_00  = 3'd3;
	localparam logic [2:0] REG_RM_01  = 3'd4;
	localparam logic [2:0] REG_RM_11  = 3'd5;

	localparam logic [23:0] EPS_RESET = 24'd0;
	localparam logic [15:0] RM_RESET  = 16'd4096;

	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

	localparam int XDIV_STEPS = 64;
	localparam int SQRT_STEPS = 32;
	localparam int FDIV_STEPS = 64;

	typedef struct packed {
		logic [23:0] eps_00;
		logic [23:0] eps_01;
		logic [23:0] eps_11;
		logic [15:0] rm_00;
		logic [15:0] rm_01;
		logic [15:0] rm_11;
	} cfg_t;

	typedef struct packed {
		logic        wf;
		logic        zero_d;
		logic [23:0] eps;
	} meta_t;

	// front end to divider
	typedef struct packed {
		meta_t        meta;
		logic [103:0] num;
		logic [95:0]  den;
		logic [31:0]  dsq;
	} fres_t;

	// divider to polynomial stages
	typedef struct packed {
		meta_t       meta;
		logic        xovf;
		logic [63:0] x;
		logic [31:0] root;
	} rres_t;

	// polynomial stages to force divider and output
	typedef struct packed {
		meta_t        meta;
		logic         xovf;
		logic [31:0]  root;
		logic [63:0]  energy;
		logic         err_e;
		logic         neg_f;
		logic         a_big;
		logic [118:0] amag;
	} pres_t;

	typedef struct packed {
		logic [63:0] val;
		logic        err;
	} sat_t;

	// magnitude and sign to saturated two's complement
	function automatic sat_t sat64(input logic big, input logic [63:0] mag, input logic neg);
		sat_t r;
		r.err = 1'b0;
		r.val = mag;
		if (neg) begin
			if (big || mag > NEG_MIN) begin
				r.val = NEG_MIN;
				r.err = 1'b1;
			end else begin
				r.val = ~mag + 64'd1;
			end
		end else if (big || mag > POS_MAX) begin
			r.val = POS_MAX;
			r.err = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/ljpef_front.sv =====
module ljpef_front import ljpef_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  logic        t1,
	input  logic        t2,
	input  logic [31:0] dsq,
	input  logic        wf,
	input  cfg_t        cfg,
	output logic        out_v,
	output fres_t       fout
);

	logic [23:0] eps_sel;
	logic [15:0] rm_sel;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic [15:0] rm_s1;
	logic [31:0] dsq_s1, dsq_s2, dsq_s3, dsq_s4, dsq_s5;
	logic [31:0] m2_s2, m2_s3;
	logic [63:0] d2_s2;
	logic [63:0] m4_s3, d3lo_s3, d3hi_s3;
	logic [63:0] m6lo_s4, m6hi_s4;
	logic [95:0] den_s4, den_s5;
	logic [103:0] num_s5;

	always_comb begin
		if (!t1 && !t2) begin
			eps_sel = cfg.eps_00;
			rm_sel  = cfg.rm_00;
		end else if (t1 && t2) begin
			eps_sel = cfg.eps_11;
			rm_sel  = cfg.rm_11;
		end else begin
			eps_sel = cfg.eps_01;
			rm_sel  = cfg.rm_01;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1.wf     <= wf;
			meta_s1.zero_d <= (dsq == 32'd0);
			meta_s1.eps    <= eps_sel;
			rm_s1          <= rm_sel;
			dsq_s1         <= dsq;

			meta_s2 <= meta_s1;
			dsq_s2  <= dsq_s1;
			m2_s2   <= 32'(rm_s1) * 32'(rm_s1);
			d2_s2   <= 64'(dsq_s1) * 64'(dsq_s1);

			meta_s3 <= meta_s2;
			dsq_s3  <= dsq_s2;
			m2_s3   <= m2_s2;
			m4_s3   <= 64'(m2_s2) * 64'(m2_s2);
			d3lo_s3 <= 64'(d2_s2[31:0]) * 64'(dsq_s2);
			d3hi_s3 <= 64'(d2_s2[63:32]) * 64'(dsq_s2);

			// split rm^4 against rm^2 to keep each product 32 by 32
			meta_s4 <= meta_s3;
			dsq_s4  <= dsq_s3;
			m6lo_s4 <= 64'(m4_s3[31:0]) * 64'(m2_s3);
			m6hi_s4 <= 64'(m4_s3[63:32]) * 64'(m2_s3);
			den_s4  <= 96'(d3lo_s3) + {d3hi_s3, 32'd0};

			meta_s5 <= meta_s4;
			dsq_s5  <= dsq_s4;
			num_s5  <= {96'(m6lo_s4) + {m6hi_s4, 32'd0}, 8'd0};
			den_s5  <= den_s4;
		end
	end

	assign out_v     = v_s5;
	assign fout.meta = meta_s5;
	assign fout.num  = num_s5;
	assign fout.den  = den_s5;
	assign fout.dsq  = dsq_s5;

endmodule

// ===== rtl/ljpef_ratio.sv =====
module ljpef_ratio import ljpef_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_v,
	input  fres_t fin,
	output logic  out_v,
	output rres_t rout
);

	logic        v_s    [0:XDIV_STEPS];
	meta_t       meta_s [0:XDIV_STEPS];
	logic        xovf_s [0:XDIV_STEPS];
	logic [95:0] rem_s  [0:XDIV_STEPS];
	logic [63:0] lo_s   [0:XDIV_STEPS];
	logic [95:0] den_s  [0:XDIV_STEPS];
	logic [63:0] sv_s   [0:XDIV_STEPS];
	logic [63:0] res_s  [0:XDIV_STEPS];

	logic [96:0] trial [0:XDIV_STEPS-1];
	logic        ge    [0:XDIV_STEPS-1];
	logic [95:0] rem_n [0:XDIV_STEPS-1];
	logic [63:0] lo_n  [0:XDIV_STEPS-1];
	logic [63:0] sum_r [0:XDIV_STEPS-1];
	logic [63:0] sv_n  [0:XDIV_STEPS-1];
	logic [63:0] res_n [0:XDIV_STEPS-1];

	// one quotient bit per stage; the square root of r^2 rides along
	always_comb begin
		for (int i = 0; i < XDIV_STEPS; i++) begin
			trial[i] = {rem_s[i], lo_s[i][63]};
			ge[i]    = trial[i] >= {1'b0, den_s[i]};
			rem_n[i] = ge[i] ? 96'(trial[i] - {1'b0, den_s[i]}) : trial[i][95:0];
			lo_n[i]  = {lo_s[i][62:0], ge[i]};
			sv_n[i]  = sv_s[i];
			res_n[i] = res_s[i];
			sum_r[i] = '0;
			if (i < SQRT_STEPS) begin
				sum_r[i] = res_s[i] + (64'd1 << (2 * (SQRT_STEPS - 1 - i)));
				if (sv_s[i] >= sum_r[i]) begin
					sv_n[i]  = sv_s[i] - sum_r[i];
					res_n[i] = (res_s[i] >> 1) + (64'd1 << (2 * (SQRT_STEPS - 1 - i)));
				end else begin
					res_n[i] = res_s[i] >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= XDIV_STEPS; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
			for (int i = 0; i < XDIV_STEPS; i++) v_s[i+1] <= v_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= fin.meta;
			xovf_s[0] <= 96'(fin.num[103:64]) >= fin.den;
			rem_s[0]  <= 96'(fin.num[103:64]);
			lo_s[0]   <= fin.num[63:0];
			den_s[0]  <= fin.den;
			sv_s[0]   <= {fin.dsq, 32'd0};
			res_s[0]  <= '0;
			for (int i = 0; i < XDIV_STEPS; i++) begin
				meta_s[i+1] <= meta_s[i];
				xovf_s[i+1] <= xovf_s[i];
				rem_s[i+1]  <= rem_n[i];
				lo_s[i+1]   <= lo_n[i];
				den_s[i+1]  <= den_s[i];
				sv_s[i+1]   <= sv_n[i];
				res_s[i+1]  <= res_n[i];
			end
		end
	end

	assign out_v     = v_s[XDIV_STEPS];
	assign rout.meta = meta_s[XDIV_STEPS];
	assign rout.xovf = xovf_s[XDIV_STEPS];
	assign rout.x    = lo_s[XDIV_STEPS];
	assign rout.root = res_s[XDIV_STEPS][31:0];

endmodule

// ===== rtl/ljpef_poly.sv =====
module ljpef_poly import ljpef_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_v,
	input  rres_t rin,
	output logic  out_v,
	output pres_t pout
);

	localparam logic [63:0] ONE_X = 64'h1_0000_0000;
	localparam logic [63:0] TWO_X = 64'h2_0000_0000;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	logic xovf_s1, xovf_s2, xovf_s3, xovf_s4, xovf_s5, xovf_s6;
	logic [31:0] root_s1, root_s2, root_s3, root_s4, root_s5, root_s6;
	logic nege_s1, nege_s2, nege_s3, nege_s4, nege_s5;
	logic negf_s1, negf_s2, negf_s3, negf_s4, negf_s5, negf_s6;
	logic [63:0] x_s1, de_s1, df_s1;
	logic [63:0] pe_s2 [0:3];
	logic [63:0] pf_s2 [0:3];
	logic [95:0] hp_s3, hq_s3;
	logic [55:0] ee_s4 [0:2];
	logic [55:0] ef_s4 [0:2];
	logic [103:0] emag_s5;
	logic [119:0] aq_s5;
	logic [63:0] energy_s6;
	logic err_e_s6, a_big_s6;
	logic [118:0] amag_s6;

	logic [123:0] a_full;
	sat_t esat;

	assign a_full = (124'(aq_s5) << 3) + (124'(aq_s5) << 2);
	assign esat   = sat64(|emag_s5[103:64], emag_s5[63:0], nege_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= rin.meta;
			xovf_s1 <= rin.xovf;
			root_s1 <= rin.root;
			x_s1    <= rin.x;
			nege_s1 <= rin.x < TWO_X;
			de_s1   <= (rin.x < TWO_X) ? TWO_X - rin.x : rin.x - TWO_X;
			negf_s1 <= rin.x < ONE_X;
			df_s1   <= (rin.x < ONE_X) ? ONE_X - rin.x : rin.x - ONE_X;

			meta_s2 <= meta_s1;
			xovf_s2 <= xovf_s1;
			root_s2 <= root_s1;
			nege_s2 <= nege_s1;
			negf_s2 <= negf_s1;
			pe_s2[0] <= 64'(x_s1[31:0]) * 64'(de_s1[31:0]);
			pe_s2[1] <= 64'(x_s1[31:0]) * 64'(de_s1[63:32]);
			pe_s2[2] <= 64'(x_s1[63:32]) * 64'(de_s1[31:0]);
			pe_s2[3] <= 64'(x_s1[63:32]) * 64'(de_s1[63:32]);
			pf_s2[0] <= 64'(x_s1[31:0]) * 64'(df_s1[31:0]);
			pf_s2[1] <= 64'(x_s1[31:0]) * 64'(df_s1[63:32]);
			pf_s2[2] <= 64'(x_s1[63:32]) * 64'(df_s1[31:0]);
			pf_s2[3] <= 64'(x_s1[63:32]) * 64'(df_s1[63:32]);

			// drop the low 32 fraction bits so the product is back in Q32.32
			meta_s3 <= meta_s2;
			xovf_s3 <= xovf_s2;
			root_s3 <= root_s2;
			nege_s3 <= nege_s2;
			negf_s3 <= negf_s2;
			hp_s3 <= 96'((128'(pe_s2[0]) + {32'd0, pe_s2[1], 32'd0}
				+ {32'd0, pe_s2[2], 32'd0} + {pe_s2[3], 64'd0}) >> 32);
			hq_s3 <= 96'((128'(pf_s2[0]) + {32'd0, pf_s2[1], 32'd0}
				+ {32'd0, pf_s2[2], 32'd0} + {pf_s2[3], 64'd0}) >> 32);

			meta_s4 <= meta_s3;
			xovf_s4 <= xovf_s3;
			root_s4 <= root_s3;
			nege_s4 <= nege_s3;
			negf_s4 <= negf_s3;
			ee_s4[0] <= 56'(hp_s3[31:0]) * 56'(meta_s3.eps);
			ee_s4[1] <= 56'(hp_s3[63:32]) * 56'(meta_s3.eps);
			ee_s4[2] <= 56'(hp_s3[95:64]) * 56'(meta_s3.eps);
			ef_s4[0] <= 56'(hq_s3[31:0]) * 56'(meta_s3.eps);
			ef_s4[1] <= 56'(hq_s3[63:32]) * 56'(meta_s3.eps);
			ef_s4[2] <= 56'(hq_s3[95:64]) * 56'(meta_s3.eps);

			meta_s5 <= meta_s4;
			xovf_s5 <= xovf_s4;
			root_s5 <= root_s4;
			nege_s5 <= nege_s4;
			negf_s5 <= negf_s4;
			emag_s5 <= 104'((120'(ee_s4[0]) + {32'd0, ee_s4[1], 32'd0}
				+ {ee_s4[2], 64'd0}) >> 16);
			aq_s5 <= 120'(ef_s4[0]) + {32'd0, ef_s4[1], 32'd0} + {ef_s4[2], 64'd0};

			meta_s6   <= meta_s5;
			xovf_s6   <= xovf_s5;
			root_s6   <= root_s5;
			negf_s6   <= negf_s5;
			energy_s6 <= esat.val;
			err_e_s6  <= esat.err;
			a_big_s6  <= |a_full[123:119];
			amag_s6   <= a_full[118:0];
		end
	end

	assign out_v       = v_s6;
	assign pout.meta   = meta_s6;
	assign pout.xovf   = xovf_s6;
	assign pout.root   = root_s6;
	assign pout.energy = energy_s6;
	assign pout.err_e  = err_e_s6;
	assign pout.neg_f  = negf_s6;
	assign pout.a_big  = a_big_s6;
	assign pout.amag   = amag_s6;

endmodule

// ===== rtl/ljpef_fdiv.sv =====
module ljpef_fdiv import ljpef_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  pres_t       pin,
	output logic        out_v,
	output pres_t       pout,
	output logic [63:0] fq,
	output logic        fovf
);

	logic        v_s    [0:FDIV_STEPS];
	pres_t       side_s [0:FDIV_STEPS];
	logic        fovf_s [0:FDIV_STEPS];
	logic [31:0] rem_s  [0:FDIV_STEPS];
	logic [63:0] lo_s   [0:FDIV_STEPS];

	logic [32:0] trial [0:FDIV_STEPS-1];
	logic        ge    [0:FDIV_STEPS-1];
	logic [31:0] rem_n [0:FDIV_STEPS-1];
	logic [63:0] lo_n  [0:FDIV_STEPS-1];

	logic [126:0] numer;

	assign numer = {pin.amag, 8'd0};

	always_comb begin
		for (int i = 0; i < FDIV_STEPS; i++) begin
			trial[i] = {rem_s[i], lo_s[i][63]};
			ge[i]    = trial[i] >= {1'b0, side_s[i].root};
			rem_n[i] = ge[i] ? 32'(trial[i] - {1'b0, side_s[i].root}) : trial[i][31:0];
			lo_n[i]  = {lo_s[i][62:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= FDIV_STEPS; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
			for (int i = 0; i < FDIV_STEPS; i++) v_s[i+1] <= v_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= pin;
			// quotient at or above 2^64 saturates anyway
			fovf_s[0] <= numer[126:64] >= 63'(pin.root);
			rem_s[0]  <= numer[95:64];
			lo_s[0]   <= numer[63:0];
			for (int i = 0; i < FDIV_STEPS; i++) begin
				side_s[i+1] <= side_s[i];
				fovf_s[i+1] <= fovf_s[i];
				rem_s[i+1]  <= rem_n[i];
				lo_s[i+1]   <= lo_n[i];
			end
		end
	end

	assign out_v = v_s[FDIV_STEPS];
	assign pout  = side_s[FDIV_STEPS];
	assign fq    = lo_s[FDIV_STEPS];
	assign fovf  = fovf_s[FDIV_STEPS];

endmodule

// ===== rtl/lennard_jones_pair_energy_force_core.sv =====
// Lennard-Jones 12-6 pair energy and scalar force, fixed point.
// Input channel (in_valid / in_stall): atom types, r^2 in Q16.16 and a force request.
// Output channel (out_valid / out_stall): energy and force in Q32.32 with saturation,
// force_valid and range_error. One result beat per input beat, in order.
// Configuration: write cfg_index / cfg_data with cfg_valid; cfg_ready is always high.
// Indexes 0..2 are well depths (Q8.16), 3..5 minimum distances (Q4.12); others drop.
// Write registers only while no pair is in flight.
// The pipeline has 5 power stages, a 65-stage x = rm^6/r^6 divider with the
// r square root alongside, 6 product stages, a 65-stage force divider and the output
// register. The two dividers, one quotient bit per stage, set the depth.
// Throughput is one pair per cycle while the output is not stalled.
// When out_stall is high with a result waiting, the whole pipeline holds and in_stall
// rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets well depths to 0 and minimum distances to 1.0.
module lennard_jones_pair_energy_force_core import ljpef_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               first_type,
	input  logic               second_type,
	input  logic [31:0]        dist_squared,
	input  logic               want_force,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] pair_energy,
	output logic signed [63:0] pair_force,
	output logic               force_valid,
	output logic               range_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	cfg_t  cfg_q;
	logic  en;
	logic  front_v, ratio_v, poly_v, fdiv_v;
	fres_t front_out;
	rres_t ratio_out;
	pres_t poly_out, fdiv_out;
	logic [63:0] fq;
	logic  fovf;

	sat_t fsat;
	logic [63:0] e_nxt, f_nxt;
	logic err_nxt;

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eps_00 <= EPS_RESET;
			cfg_q.eps_01 <= EPS_RESET;
			cfg_q.eps_11 <= EPS_RESET;
			cfg_q.rm_00  <= RM_RESET;
			cfg_q.rm_01  <= RM_RESET;
			cfg_q.rm_11  <= RM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EPS_00: cfg_q.eps_00 <= cfg_data;
				REG_EPS_01: cfg_q.eps_01 <= cfg_data;
				REG_EPS_11: cfg_q.eps_11 <= cfg_data;
				REG_RM_00:  cfg_q.rm_00  <= cfg_data[15:0];
				REG_RM_01:  cfg_q.rm_01  <= cfg_data[15:0];
				REG_RM_11:  cfg_q.rm_11  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ljpef_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in_valid),
		.t1     (first_type),
		.t2     (second_type),
		.dsq    (dist_squared),
		.wf     (want_force),
		.cfg    (cfg_q),
		.out_v  (front_v),
		.fout   (front_out)
	);

	ljpef_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (front_v),
		.fin    (front_out),
		.out_v  (ratio_v),
		.rout   (ratio_out)
	);

	ljpef_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (ratio_v),
		.rin    (ratio_out),
		.out_v  (poly_v),
		.pout   (poly_out)
	);

	ljpef_fdiv u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (poly_v),
		.pin    (poly_out),
		.out_v  (fdiv_v),
		.pout   (fdiv_out),
		.fq     (fq),
		.fovf   (fovf)
	);

	assign fsat = sat64(fovf, fq, fdiv_out.neg_f);

	always_comb begin
		e_nxt   = fdiv_out.energy;
		f_nxt   = '0;
		err_nxt = fdiv_out.err_e;
		if (fdiv_out.meta.wf) begin
			if (fdiv_out.a_big) begin
				f_nxt   = fdiv_out.neg_f ? NEG_MIN : POS_MAX;
				err_nxt = 1'b1;
			end else begin
				f_nxt   = fsat.val;
				err_nxt = fdiv_out.err_e | fsat.err;
			end
		end
		// x beyond Q32.32: saturate unless the well depth is zero
		if (fdiv_out.xovf) begin
			if (fdiv_out.meta.eps != 24'd0) begin
				e_nxt   = POS_MAX;
				f_nxt   = fdiv_out.meta.wf ? POS_MAX : 64'd0;
				err_nxt = 1'b1;
			end else begin
				e_nxt   = '0;
				f_nxt   = '0;
				err_nxt = 1'b0;
			end
		end
		if (fdiv_out.meta.zero_d) begin
			e_nxt   = POS_MAX;
			f_nxt   = fdiv_out.meta.wf ? POS_MAX : 64'd0;
			err_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= fdiv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_energy <= e_nxt;
			pair_force  <= f_nxt;
			force_valid <= fdiv_out.meta.wf;
			range_error <= err_nxt;
		end
	end

	a_force_zero_unless_asked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !force_valid |-> pair_force == 64'sd0)
		else $error("force not requested but nonzero");

	// well depth below 256 bounds the attractive energy well below 2^40 in Q32.32
	a_energy_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pair_energy[63] |-> &pair_energy[63:40])
		else $error("negative energy beyond the well depth");

	a_pipe_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fdiv_v && !en |=> fdiv_v)
		else $error("pipeline valid lost while stalled");

endmodule
